[design/lsac_pkg.sv]
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types and constants for the RV64 load/store access classifier.
// ----------------------------------------------------------------------------
package lsac_pkg;

  localparam int unsigned XLEN = 64;

  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [1:0] QuadC0 = 2'b00;
  localparam logic [1:0] QuadC2 = 2'b10;

  localparam logic [2:0] CF3Lw = 3'd2;
  localparam logic [2:0] CF3Ld = 3'd3;
  localparam logic [2:0] CF3Sw = 3'd6;
  localparam logic [2:0] CF3Sd = 3'd7;

  localparam logic [4:0] RegSp = 5'd2;

  localparam logic [11:0] CsrCycle    = 12'hc00;
  localparam logic [11:0] CsrTime     = 12'hc01;
  localparam logic [11:0] CsrInstret  = 12'hc02;
  localparam logic [11:0] CsrMcycle   = 12'hb00;
  localparam logic [11:0] CsrMinstret = 12'hb02;

  localparam logic [XLEN-1:0] TimerA0 = 64'h0000_0000_0200_bff8;
  localparam logic [XLEN-1:0] TimerA1 = 64'h0000_0000_0200_bffc;
  localparam logic [XLEN-1:0] TimerB0 = 64'h0000_0000_1000_3000;
  localparam logic [XLEN-1:0] TimerB1 = 64'h0000_0000_1000_3004;
  localparam logic [XLEN-1:0] TimerC0 = 64'h0000_0000_1200_0048;
  localparam logic [XLEN-1:0] TimerC1 = 64'h0000_0000_1200_004c;

  localparam logic [XLEN-1:0] DevALo = 64'h0000_0000_0200_0000;
  localparam logic [XLEN-1:0] DevAHi = 64'h0000_0000_0201_0000;
  localparam logic [XLEN-1:0] DevBLo = 64'h0000_0000_0c00_0000;
  localparam logic [XLEN-1:0] DevBHi = 64'h0000_0000_1000_0000;
  localparam logic [XLEN-1:0] DevCLo = 64'h0000_0000_1000_3000;
  localparam logic [XLEN-1:0] DevCHi = 64'h0000_0000_1000_4000;

  typedef struct packed {
    logic              is_memory;
    logic              is_store;
    logic [4:0]        data_reg;
    logic [4:0]        base_reg;
    logic [3:0]        access_bytes;
    logic signed [11:0] offset;
    logic              counter_csr_read;
  } lsac_dec_t;

  typedef struct packed {
    lsac_dec_t       dec;
    logic [XLEN-1:0] effective_address;
  } lsac_agen_t;

  typedef struct packed {
    lsac_agen_t agen;
    logic       timer_load;
    logic       device_hit;
    logic       misaligned;
  } lsac_res_t;

endpackage

[design/lsac_if.sv]
// ----------------------------------------------------------------------------
// lsac_if
// Request and result channels of the access classifier (valid/ready).
// ----------------------------------------------------------------------------
interface lsac_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [63:0] base_value;

  modport source (output valid, output instruction, output base_value, input ready);
  modport sink   (input valid, input instruction, input base_value, output ready);
endinterface

interface lsac_rsp_if;
  logic               valid;
  logic               ready;
  logic               is_memory;
  logic               is_store;
  logic [4:0]         data_reg;
  logic [4:0]         base_reg;
  logic [3:0]         access_bytes;
  logic signed [11:0] offset;
  logic [63:0]        effective_address;
  logic               timer_load;
  logic               device_hit;
  logic               misaligned;
  logic               counter_csr_read;

  modport source (
    output valid, output is_memory, output is_store, output data_reg, output base_reg,
    output access_bytes, output offset, output effective_address, output timer_load,
    output device_hit, output misaligned, output counter_csr_read, input ready
  );
  modport sink (
    input valid, input is_memory, input is_store, input data_reg, input base_reg,
    input access_bytes, input offset, input effective_address, input timer_load,
    input device_hit, input misaligned, input counter_csr_read, output ready
  );
endinterface

[design/rv64_load_store_access_classifier.sv]
// ----------------------------------------------------------------------------
// rv64_load_store_access_classifier
// Classifies RV64 integer load/store requests, including compressed forms.
//
// Usage:
//   in_i  (sink)   : one request per handshake, instruction word plus the
//                    value of the base register it names.
//   out_o (source) : one result per request, in request order.
// Three register stages: decode, address add, region/alignment checks.
// While out_o.ready is high a new request is taken every cycle, so sustained
// throughput is 1 request per cycle, as each stage hands on its contents in
// the cycle that it takes new ones.
// The last stage is the output register.
// Each stage moves on when it is empty or its successor takes its contents,
// so a stall on out_o.ready holds every full stage and the block keeps
// filling empty stages behind it; in_i.ready drops once all three are full.
// Reset clears all stage valid bits; nothing else needs clearing.
// ----------------------------------------------------------------------------
module rv64_load_store_access_classifier (
  input  logic     clk_i,
  input  logic     rst_ni,
  lsac_req_if.sink   in_i,
  lsac_rsp_if.source out_o
);
  import lsac_pkg::*;

  logic        s1_valid, s1_ready;
  lsac_dec_t   s1_dec;
  logic [63:0] s1_base;
  logic        s2_valid, s2_ready;
  lsac_agen_t  s2_agen;
  lsac_res_t   s3_res;

  lsac_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .instruction_i(in_i.instruction),
    .base_value_i (in_i.base_value),
    .valid_o      (s1_valid),
    .ready_i      (s1_ready),
    .dec_o        (s1_dec),
    .base_value_o (s1_base)
  );

  lsac_agen u_agen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .ready_o     (s1_ready),
    .dec_i       (s1_dec),
    .base_value_i(s1_base),
    .valid_o     (s2_valid),
    .ready_i     (s2_ready),
    .agen_o      (s2_agen)
  );

  lsac_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s2_valid),
    .ready_o(s2_ready),
    .agen_i (s2_agen),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .res_o  (s3_res)
  );

  assign out_o.is_memory         = s3_res.agen.dec.is_memory;
  assign out_o.is_store          = s3_res.agen.dec.is_store;
  assign out_o.data_reg          = s3_res.agen.dec.data_reg;
  assign out_o.base_reg          = s3_res.agen.dec.base_reg;
  assign out_o.access_bytes      = s3_res.agen.dec.access_bytes;
  assign out_o.offset            = s3_res.agen.dec.offset;
  assign out_o.effective_address = s3_res.agen.effective_address;
  assign out_o.timer_load        = s3_res.timer_load;
  assign out_o.device_hit        = s3_res.device_hit;
  assign out_o.misaligned        = s3_res.misaligned;
  assign out_o.counter_csr_read  = s3_res.agen.dec.counter_csr_read;

  // non-memory results carry a zero address and size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_memory) |->
      (out_o.effective_address == 64'd0 && out_o.access_bytes == 4'd0 &&
       !out_o.timer_load && !out_o.device_hit && !out_o.misaligned))
    else $error("non-memory result carries access fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.timer_load) |-> (out_o.is_memory && !out_o.is_store))
    else $error("timer flag on a non-load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.misaligned) |-> (out_o.is_memory && out_o.access_bytes != 4'd1))
    else $error("byte access flagged misaligned");

  // with the sink ready, an accepted request comes out through the stage registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) ##1 out_o.ready ##1 out_o.ready |=> out_o.valid)
    else $error("request lost in pipeline");

endmodule

[design/lsac_decode.sv]
// ----------------------------------------------------------------------------
// lsac_decode
// Stage 1: decodes 32-bit and compressed integer loads/stores and counter
// CSR reads.
// ----------------------------------------------------------------------------
module lsac_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [31:0]         instruction_i,
  input  logic [63:0]         base_value_i,
  output logic                valid_o,
  input  logic                ready_i,
  output lsac_pkg::lsac_dec_t dec_o,
  output logic [63:0]         base_value_o
);
  import lsac_pkg::*;

  logic      valid_q;
  lsac_dec_t dec_d, dec_q;
  logic [63:0] base_q;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [2:0]  cf3;
  logic [1:0]  quad;
  logic [11:0] imm;
  logic [8:0]  uimm;
  logic        dbl;

  assign op   = instruction_i[6:0];
  assign f3   = instruction_i[14:12];
  assign cf3  = instruction_i[15:13];
  assign quad = instruction_i[1:0];
  assign dbl  = cf3[0];

  always_comb begin
    dec_d = '0;
    imm   = '0;
    uimm  = '0;
    if (quad == 2'b11) begin
      if ((op == OpLoad && f3 != 3'd7) || (op == OpStore && !f3[2])) begin
        dec_d.is_memory    = 1'b1;
        dec_d.is_store     = (op == OpStore);
        dec_d.base_reg     = instruction_i[19:15];
        dec_d.data_reg     = dec_d.is_store ? instruction_i[24:20] : instruction_i[11:7];
        dec_d.access_bytes = 4'(4'd1 << f3[1:0]);
        imm = dec_d.is_store ? {instruction_i[31:25], instruction_i[11:7]}
                             : instruction_i[31:20];
        dec_d.offset = signed'(imm);
      end
    end else begin
      if (quad == QuadC0 && cf3[1]) begin
        // C.LW / C.LD / C.SW / C.SD
        dec_d.is_memory = 1'b1;
        dec_d.is_store  = cf3[2];
        dec_d.data_reg  = {2'b01, instruction_i[4:2]};
        dec_d.base_reg  = {2'b01, instruction_i[9:7]};
        if (dbl) begin
          uimm = {1'b0, instruction_i[6:5], instruction_i[12:10], 3'b000};
        end else begin
          uimm = {2'b00, instruction_i[5], instruction_i[12:10], instruction_i[6], 2'b00};
        end
      end else if (quad == QuadC2 && (cf3 == CF3Lw || cf3 == CF3Ld)
                   && instruction_i[11:7] != 5'd0) begin
        // C.LWSP / C.LDSP
        dec_d.is_memory = 1'b1;
        dec_d.data_reg  = instruction_i[11:7];
        dec_d.base_reg  = RegSp;
        if (dbl) begin
          uimm = {instruction_i[4:2], instruction_i[12], instruction_i[6:5], 3'b000};
        end else begin
          uimm = {1'b0, instruction_i[3:2], instruction_i[12], instruction_i[6:4], 2'b00};
        end
      end else if (quad == QuadC2 && (cf3 == CF3Sw || cf3 == CF3Sd)) begin
        // C.SWSP / C.SDSP, data register reported as zero
        dec_d.is_memory = 1'b1;
        dec_d.is_store  = 1'b1;
        dec_d.base_reg  = RegSp;
        if (dbl) begin
          uimm = {instruction_i[9:7], instruction_i[12:10], 3'b000};
        end else begin
          uimm = {1'b0, instruction_i[8:7], instruction_i[12:9], 2'b00};
        end
      end
      if (dec_d.is_memory) begin
        dec_d.access_bytes = dbl ? 4'd8 : 4'd4;
      end
      dec_d.offset = signed'({3'b000, uimm});
    end

    dec_d.counter_csr_read = (op == OpSystem) && (f3 != 3'd0) &&
      (instruction_i[31:20] inside {CsrCycle, CsrTime, CsrInstret, CsrMcycle, CsrMinstret});
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q  <= dec_d;
      base_q <= base_value_i;
    end
  end

  assign valid_o      = valid_q;
  assign dec_o        = dec_q;
  assign base_value_o = base_q;

endmodule

[design/lsac_agen.sv]
// ----------------------------------------------------------------------------
// lsac_agen
// Stage 2: 64-bit wrapping effective address, base plus sign-extended offset.
// ----------------------------------------------------------------------------
module lsac_agen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lsac_pkg::lsac_dec_t  dec_i,
  input  logic [63:0]          base_value_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output lsac_pkg::lsac_agen_t agen_o
);
  import lsac_pkg::*;

  logic       valid_q;
  lsac_agen_t agen_d, agen_q;

  always_comb begin
    agen_d.dec = dec_i;
    agen_d.effective_address = '0;
    if (dec_i.is_memory) begin
      agen_d.effective_address = base_value_i + XLEN'(dec_i.offset);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      agen_q <= agen_d;
    end
  end

  assign valid_o = valid_q;
  assign agen_o  = agen_q;

endmodule

[design/lsac_classify.sv]
// ----------------------------------------------------------------------------
// lsac_classify
// Stage 3: timer, strict device and alignment checks; holds the result
// register.
// ----------------------------------------------------------------------------
module lsac_classify (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lsac_pkg::lsac_agen_t agen_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output lsac_pkg::lsac_res_t  res_o
);
  import lsac_pkg::*;

  logic      valid_q;
  lsac_res_t res_d, res_q;
  logic [XLEN-1:0] ea;
  logic [2:0]      amask;

  assign ea    = agen_i.effective_address;
  assign amask = agen_i.dec.access_bytes[2:0] - 3'd1;

  always_comb begin
    res_d.agen = agen_i;
    res_d.timer_load = agen_i.dec.is_memory && !agen_i.dec.is_store &&
      (ea == TimerA0 || ea == TimerA1 || ea == TimerB0 ||
       ea == TimerB1 || ea == TimerC0 || ea == TimerC1);
    res_d.device_hit = agen_i.dec.is_memory &&
      ((ea >= DevALo && ea < DevAHi) ||
       (ea >= DevBLo && ea < DevBHi) ||
       (ea >= DevCLo && ea < DevCHi));
    res_d.misaligned = agen_i.dec.is_memory && ((ea[2:0] & amask) != 3'd0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[tb/tb_rv64_load_store_access_classifier.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv64_load_store_access_classifier
// Drives instruction/base requests into the classifier with random gaps on
// the request side and random stalls on the result side. Every accepted
// request is decoded independently here and the expected classification is
// queued; each result taken from the block is checked field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_rv64_load_store_access_classifier;
  import lsac_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned NumRandom  = 1700;

  typedef struct packed {
    logic               is_memory;
    logic               is_store;
    logic [4:0]         data_reg;
    logic [4:0]         base_reg;
    logic [3:0]         access_bytes;
    logic signed [11:0] offset;
    logic [63:0]        effective_address;
    logic               timer_load;
    logic               device_hit;
    logic               misaligned;
    logic               counter_csr_read;
  } access_t;

  class access_checker;
    access_t     expected_access[$];
    int unsigned errors;

    function access_t classify_access(logic [31:0] ins, logic [63:0] base);
      access_t     r;
      logic [2:0]  f3;
      logic [11:0] imm;
      logic [8:0]  u;
      logic [63:0] off;
      logic [63:0] ea;
      logic [11:0] csr;
      r   = '0;
      off = '0;
      u   = '0;
      if (ins[1:0] == 2'b11) begin
        f3 = ins[14:12];
        if ((ins[6:0] == OpLoad && f3 != 3'd7) || (ins[6:0] == OpStore && !f3[2])) begin
          r.is_memory    = 1'b1;
          r.is_store     = (ins[6:0] == OpStore);
          r.base_reg     = ins[19:15];
          r.data_reg     = r.is_store ? ins[24:20] : ins[11:7];
          r.access_bytes = 4'd1 << f3[1:0];
          imm            = r.is_store ? {ins[31:25], ins[11:7]} : ins[31:20];
          off            = {{52{imm[11]}}, imm};
        end
      end else begin
        f3 = ins[15:13];
        if (ins[1:0] == QuadC0 && (f3 == CF3Lw || f3 == CF3Ld || f3 == CF3Sw || f3 == CF3Sd)) begin
          r.is_memory = 1'b1;
          r.is_store  = f3[2];
          r.data_reg  = {2'b01, ins[4:2]};
          r.base_reg  = {2'b01, ins[9:7]};
          u[5:3]      = ins[12:10];
          if (f3[0]) begin
            u[7:6] = ins[6:5];
          end else begin
            u[2] = ins[6];
            u[6] = ins[5];
          end
        end else if (ins[1:0] == QuadC2 && (f3 == CF3Lw || f3 == CF3Ld) && ins[11:7] != 5'd0) begin
          r.is_memory = 1'b1;
          r.data_reg  = ins[11:7];
          r.base_reg  = RegSp;
          u[5]        = ins[12];
          if (f3[0]) begin
            u[4:3] = ins[6:5];
            u[8:6] = ins[4:2];
          end else begin
            u[4:2] = ins[6:4];
            u[7:6] = ins[3:2];
          end
        end else if (ins[1:0] == QuadC2 && (f3 == CF3Sw || f3 == CF3Sd)) begin
          r.is_memory = 1'b1;
          r.is_store  = 1'b1;
          r.base_reg  = RegSp;
          if (f3[0]) begin
            u[5:3] = ins[12:10];
            u[8:6] = ins[9:7];
          end else begin
            u[5:2] = ins[12:9];
            u[7:6] = ins[8:7];
          end
        end
        if (r.is_memory) r.access_bytes = f3[0] ? 4'd8 : 4'd4;
        off = {55'd0, u};
      end
      r.offset = off[11:0];
      if (r.is_memory) begin
        ea                  = base + off;
        r.effective_address = ea;
        r.timer_load        = !r.is_store &&
                              (ea == TimerA0 || ea == TimerA1 || ea == TimerB0 ||
                               ea == TimerB1 || ea == TimerC0 || ea == TimerC1);
        r.device_hit        = (ea >= DevALo && ea < DevAHi) ||
                              (ea >= DevBLo && ea < DevBHi) ||
                              (ea >= DevCLo && ea < DevCHi);
        r.misaligned        = (ea[3:0] & (r.access_bytes - 4'd1)) != 4'd0;
      end
      csr = ins[31:20];
      r.counter_csr_read = ins[6:0] == OpSystem && ins[14:12] != 3'd0 &&
                           (csr == CsrCycle || csr == CsrTime || csr == CsrInstret ||
                            csr == CsrMcycle || csr == CsrMinstret);
      return r;
    endfunction

    function void note_request(logic [31:0] ins, logic [63:0] base);
      expected_access.push_back(classify_access(ins, base));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(access_t got);
      access_t want;
      if (expected_access.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_access.pop_front();
      compare_field("is_memory", want.is_memory, got.is_memory);
      compare_field("is_store", want.is_store, got.is_store);
      compare_field("data_reg", want.data_reg, got.data_reg);
      compare_field("base_reg", want.base_reg, got.base_reg);
      compare_field("access_bytes", want.access_bytes, got.access_bytes);
      compare_field("offset", {52'd0, want.offset}, {52'd0, got.offset});
      compare_field("effective_address", want.effective_address, got.effective_address);
      compare_field("timer_load", want.timer_load, got.timer_load);
      compare_field("device_hit", want.device_hit, got.device_hit);
      compare_field("misaligned", want.misaligned, got.misaligned);
      compare_field("counter_csr_read", want.counter_csr_read, got.counter_csr_read);
    endfunction

    function int outstanding();
      return expected_access.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;
  int unsigned cycle_count;

  access_checker chk = new();

  lsac_req_if req_if();
  lsac_rsp_if rsp_if();

  rv64_load_store_access_classifier DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  localparam logic [63:0] HotAddr [16] = '{
    TimerA0, TimerA1, TimerB0, TimerB1, TimerC0, TimerC1,
    DevALo, DevAHi - 64'd1, DevAHi, DevBLo - 64'd1, DevBLo, DevBHi - 64'd1,
    DevBHi, DevCLo - 64'd1, DevCHi - 64'd1, DevCHi
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // monitor: results are checked before the same edge's request is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        chk.check_result('{
          is_memory:         rsp_if.is_memory,
          is_store:          rsp_if.is_store,
          data_reg:          rsp_if.data_reg,
          base_reg:          rsp_if.base_reg,
          access_bytes:      rsp_if.access_bytes,
          offset:            rsp_if.offset,
          effective_address: rsp_if.effective_address,
          timer_load:        rsp_if.timer_load,
          device_hit:        rsp_if.device_hit,
          misaligned:        rsp_if.misaligned,
          counter_csr_read:  rsp_if.counter_csr_read
        });
      end
      if (req_if.valid && req_if.ready) chk.note_request(req_if.instruction, req_if.base_value);
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_request(input logic [31:0] ins, input logic [63:0] base);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.instruction <= ins;
    req_if.base_value  <= base;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] enc_load(logic [2:0] f3, logic [4:0] rd, logic [4:0] rs1,
                                           logic [11:0] imm);
    return {imm, rs1, f3, rd, OpLoad};
  endfunction

  function automatic logic [31:0] enc_store(logic [2:0] f3, logic [4:0] rs2, logic [4:0] rs1,
                                            logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction

  initial begin
    logic [31:0] ins;
    logic [63:0] base;
    logic [63:0] target;
    access_t     probe;
    int          k;
    calm               = 1'b0;
    cycle_count        = 0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.instruction = '0;
    req_if.base_value  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every load/store width, compressed forms, boundaries, CSRs
    send_request(enc_load(3'd0, 5'd1, 5'd2, 12'h800), 64'd0);
    send_request(enc_load(3'd1, 5'd31, 5'd31, 12'h7ff), '1);
    send_request(enc_load(3'd2, 5'd5, 5'd6, 12'h000), TimerB0);
    send_request(enc_load(3'd3, 5'd7, 5'd8, 12'h008), TimerA0 - 64'd8);
    send_request(enc_load(3'd4, 5'd9, 5'd10, 12'hfff), DevBHi);
    send_request(enc_load(3'd5, 5'd11, 5'd12, 12'h001), DevCLo);
    send_request(enc_load(3'd6, 5'd13, 5'd14, 12'h004), TimerC0);
    send_request(enc_load(3'd7, 5'd15, 5'd16, 12'h010), TimerA0);
    send_request(enc_store(3'd0, 5'd17, 5'd18, 12'h000), DevALo);
    send_request(enc_store(3'd1, 5'd19, 5'd20, 12'hffe), DevAHi);
    send_request(enc_store(3'd2, 5'd21, 5'd22, 12'h004), TimerA0);
    send_request(enc_store(3'd3, 5'd23, 5'd24, 12'h003), 64'h8000_0000_0000_0000);
    send_request(enc_store(3'd4, 5'd25, 5'd26, 12'h000), 64'd0);
    send_request({16'hffff, 3'b010, 3'b111, 3'b111, 2'b11, 3'b111, QuadC0}, '1);
    send_request({16'hffff, 3'b011, 3'b111, 3'b000, 2'b11, 3'b000, QuadC0}, 64'h1000);
    send_request({16'h0000, 3'b110, 3'b101, 3'b010, 2'b10, 3'b001, QuadC0}, DevBLo);
    send_request({16'ha5a5, 3'b111, 3'b010, 3'b111, 2'b01, 3'b110, QuadC0}, 64'hfff0);
    send_request({16'h0000, 3'b010, 1'b1, 5'd31, 5'b11111, QuadC2}, 64'h7fff_fff0);
    send_request({16'hffff, 3'b011, 1'b1, 5'd1, 5'b11111, QuadC2}, TimerA0 - 64'd504);
    send_request({16'h0000, 3'b010, 1'b1, 5'd0, 5'b11111, QuadC2}, 64'h100);
    send_request({16'h0000, 3'b011, 1'b0, 5'd0, 5'b00100, QuadC2}, 64'h100);
    send_request({16'h0000, 3'b110, 6'b111111, 5'd5, QuadC2}, DevCLo - 64'd252);
    send_request({16'hffff, 3'b111, 6'b111111, 5'd31, QuadC2}, 64'd3);
    send_request({CsrCycle, 5'd0, 3'd2, 5'd1, OpSystem}, 64'd0);
    send_request({CsrMinstret, 5'd3, 3'd0, 5'd4, OpSystem}, 64'd0);

    for (int i = 0; i < NumRandom; i++) begin
      calm = ((i / 150) % 4) == 3;
      if (i == NumRandom / 2) begin
        req_if.valid <= 1'b0;
        @(negedge clk_i);
        while (chk.outstanding() != 0) @(posedge clk_i);
      end

      ins = $urandom();
      k   = $urandom_range(0, 99);
      if (k < 40) begin
        ins[6:0] = $urandom_range(0, 1) ? OpLoad : OpStore;
      end else if (k < 72) begin
        ins[1:0] = $urandom_range(0, 1) ? QuadC0 : QuadC2;
        case ($urandom_range(0, 3))
          0: ins[15:13] = CF3Lw;
          1: ins[15:13] = CF3Ld;
          2: ins[15:13] = CF3Sw;
          default: ins[15:13] = CF3Sd;
        endcase
      end else if (k < 85) begin
        ins[6:0] = OpSystem;
        case ($urandom_range(0, 5))
          0: ins[31:20] = CsrCycle;
          1: ins[31:20] = CsrTime;
          2: ins[31:20] = CsrInstret;
          3: ins[31:20] = CsrMcycle;
          4: ins[31:20] = CsrMinstret;
          default: ;
        endcase
      end

      k = $urandom_range(0, 99);
      if (k < 40) begin
        base = {$urandom(), $urandom()};
      end else if (k < 80) begin
        // aim the effective address at a timer register or a region edge
        target = HotAddr[$urandom_range(0, 15)];
        if ($urandom_range(0, 1)) target = target + 64'($urandom_range(0, 15)) - 64'd8;
        probe = chk.classify_access(ins, 64'd0);
        base  = target - probe.effective_address;
      end else if (k < 90) begin
        base = {32'd0, $urandom()};
      end else begin
        base = '1 - 64'($urandom_range(0, 4096));
      end

      send_request(ins, base);
    end
    req_if.valid <= 1'b0;
    @(negedge clk_i);

    while (chk.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (chk.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
